// ----- hw/rtl/dfu_request_state_machine_top_assert.svh -----
// ----------------------------------------------------------------------------
// DFU request engine assertion macros
// Shared property forms for the checker of the DFU request engine.
// ----------------------------------------------------------------------------
`ifndef DFU_REQUEST_STATE_MACHINE_TOP_ASSERT_SVH
`define DFU_REQUEST_STATE_MACHINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFURQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dfurq: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define DFURQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dfurq: next-cycle property failed");

// Next-cycle implication that also holds across reset.
`define DFURQ_ASSERT_RESET(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("dfurq: reset property failed");

`endif

// ----- hw/rtl/dfurq_pkg.sv -----
// ----------------------------------------------------------------------------
// DFU request engine package
// Types, protocol codes and helpers shared by the DFU request engine files.
// ----------------------------------------------------------------------------
package dfurq_pkg;

    localparam int unsigned MAX_TRANSFER = 1024;
    localparam logic [15:0] MAX_XFER_LEN = 16'(MAX_TRANSFER);

    localparam logic [31:0] ADDR_RESET_DEFAULT = 32'h0800_0000;

    localparam logic [7:0] TYPE_OUT = 8'h21;
    localparam logic [7:0] TYPE_IN  = 8'hA1;

    localparam logic [7:0] CMD_SET_ADDRESS = 8'h21;
    localparam logic [7:0] CMD_ERASE_PAGE  = 8'h41;

    localparam logic [15:0] STATUS_SIZE = 16'd6;
    localparam logic [15:0] CMD_LIST_LEN = 16'd3;
    localparam logic [15:0] CMD_BLOCK_LEN = 16'd5;

    localparam logic [7:0] REQ_DETACH    = 8'd0;
    localparam logic [7:0] REQ_DNLOAD    = 8'd1;
    localparam logic [7:0] REQ_UPLOAD    = 8'd2;
    localparam logic [7:0] REQ_GETSTATUS = 8'd3;
    localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
    localparam logic [7:0] REQ_GETSTATE  = 8'd5;
    localparam logic [7:0] REQ_ABORT     = 8'd6;

    localparam logic [1:0] FLASH_OK       = 2'd0;
    localparam logic [1:0] FLASH_BAD_ADDR = 2'd1;
    localparam logic [1:0] FLASH_NOT_ERASED = 2'd2;
    localparam logic [1:0] FLASH_VERIFY   = 2'd3;

    typedef enum logic [2:0] {
        KIND_VALIDATE = 3'd0,
        KIND_CHECK    = 3'd1,
        KIND_EXECUTE  = 3'd2,
        KIND_BLK_DONE = 3'd3,
        KIND_RESET    = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd2,
        ST_DN_SYNC  = 4'd3,
        ST_DN_BUSY  = 4'd4,
        ST_DN_IDLE  = 4'd5,
        ST_MAN_SYNC = 4'd6,
        ST_MAN      = 4'd7,
        ST_MAN_WAIT = 4'd8,
        ST_UP_IDLE  = 4'd9,
        ST_ERROR    = 4'd10
    } t_proto_state;

    typedef enum logic [2:0] {
        SS_OK     = 3'd0,
        SS_TARGET = 3'd1,
        SS_ERASED = 3'd2,
        SS_VERIFY = 3'd3,
        SS_STALL  = 3'd4
    } t_proto_status;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] length;
        logic [7:0]  command_byte;
        logic [31:0] command_address;
        logic [1:0]  flash_outcome;
        logic [23:0] busy_poll_time;
    } t_in_word;

    typedef struct packed {
        logic        stall_res;
        logic [3:0]  dfu_state_out;
        logic [2:0]  dfu_status_out;
        logic [15:0] reply_length;
        logic        reply_is_command_list;
        logic [23:0] poll_timeout;
        logic [31:0] target_address;
    } t_out_word;

    typedef struct packed {
        t_proto_state  state;
        t_proto_status status;
        logic [15:0]   blk_num;
        logic [15:0]   blk_len;
        logic [7:0]    cmd;
        logic [31:0]   addr_ptr;
    } t_ctx;

    // Flash address of a numbered block; blocks zero and one are reserved, so
    // block two sits at the pointer. The sum wraps at 32 bits.
    function automatic logic [31:0] block_address(input logic [31:0] ptr,
                                                  input logic [15:0] blk);
        logic [31:0] offs;
        offs = (32'(blk) - 32'd2) * 32'(MAX_TRANSFER);
        return ptr + offs;
    endfunction

endpackage

// ----- hw/rtl/dfurq_if.sv -----
// ----------------------------------------------------------------------------
// DFU request engine channels
// Valid/ready interfaces for request words in and reply words out.
// ----------------------------------------------------------------------------
interface dfurq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
    logic [7:0]  command_byte;
    logic [31:0] command_address;
    logic [1:0]  flash_outcome;
    logic [23:0] busy_poll_time;

    modport source (
        output valid, kind, request_type, request_code, value, index, length,
               command_byte, command_address, flash_outcome, busy_poll_time,
        input  ready
    );
    modport sink (
        input  valid, kind, request_type, request_code, value, index, length,
               command_byte, command_address, flash_outcome, busy_poll_time,
        output ready
    );
    modport monitor (
        input valid, ready, kind, request_type, request_code, value, index, length,
              command_byte, command_address, flash_outcome, busy_poll_time
    );
endinterface

interface dfurq_out_if;
    logic        valid;
    logic        ready;
    logic        stall_res;
    logic [3:0]  dfu_state_out;
    logic [2:0]  dfu_status_out;
    logic [15:0] reply_length;
    logic        reply_is_command_list;
    logic [23:0] poll_timeout;
    logic [31:0] target_address;

    modport source (
        output valid, stall_res, dfu_state_out, dfu_status_out, reply_length,
               reply_is_command_list, poll_timeout, target_address,
        input  ready
    );
    modport sink (
        input  valid, stall_res, dfu_state_out, dfu_status_out, reply_length,
               reply_is_command_list, poll_timeout, target_address,
        output ready
    );
    modport monitor (
        input valid, ready, stall_res, dfu_state_out, dfu_status_out, reply_length,
              reply_is_command_list, poll_timeout, target_address
    );
endinterface

// ----- hw/rtl/dfurq_step.sv -----
// ----------------------------------------------------------------------------
// DFU request engine step logic
// Next protocol context and reply word for one request word.
// ----------------------------------------------------------------------------
module dfurq_step (
    input  dfurq_pkg::t_ctx      i_ctx,
    input  dfurq_pkg::t_in_word  i_word,
    input  logic [31:0]          i_addr_reset,
    output dfurq_pkg::t_ctx      o_ctx,
    output dfurq_pkg::t_out_word o_res
);

    function automatic logic request_invalid(input dfurq_pkg::t_proto_state s,
                                             input dfurq_pkg::t_in_word w);
        logic busy;
        logic bad;
        busy = (s == dfurq_pkg::ST_DN_BUSY) || (s == dfurq_pkg::ST_MAN) ||
               (s == dfurq_pkg::ST_MAN_WAIT);
        case (w.request_code)
            dfurq_pkg::REQ_DNLOAD: begin
                bad = (w.request_type != dfurq_pkg::TYPE_OUT) || (w.value == 16'd1) ||
                      (w.index != 16'd0) || (w.length > dfurq_pkg::MAX_XFER_LEN) ||
                      !(s inside {dfurq_pkg::ST_IDLE, dfurq_pkg::ST_DN_IDLE});
            end
            dfurq_pkg::REQ_UPLOAD: begin
                bad = (w.request_type != dfurq_pkg::TYPE_IN) || (w.value == 16'd1) ||
                      (w.index != 16'd0) || (w.length > dfurq_pkg::MAX_XFER_LEN) ||
                      !(s inside {dfurq_pkg::ST_IDLE, dfurq_pkg::ST_UP_IDLE});
            end
            dfurq_pkg::REQ_GETSTATUS: begin
                bad = (w.request_type != dfurq_pkg::TYPE_IN) || (w.index != 16'd0) ||
                      (w.value != 16'd0) || (w.length != dfurq_pkg::STATUS_SIZE) || busy;
            end
            dfurq_pkg::REQ_CLRSTATUS: begin
                bad = (w.request_type != dfurq_pkg::TYPE_OUT) || (w.index != 16'd0) ||
                      (w.value != 16'd0) || (w.length != 16'd0) ||
                      (s != dfurq_pkg::ST_ERROR);
            end
            dfurq_pkg::REQ_GETSTATE: begin
                bad = (w.request_type != dfurq_pkg::TYPE_IN) || (w.index != 16'd0) ||
                      (w.value != 16'd0) || (w.length != 16'd1) || busy;
            end
            dfurq_pkg::REQ_ABORT: begin
                bad = (w.request_type != dfurq_pkg::TYPE_OUT) || (w.index != 16'd0) ||
                      (w.value != 16'd0) || (w.length != 16'd0) ||
                      !(s inside {dfurq_pkg::ST_IDLE, dfurq_pkg::ST_DN_SYNC,
                                  dfurq_pkg::ST_DN_IDLE, dfurq_pkg::ST_MAN_SYNC,
                                  dfurq_pkg::ST_UP_IDLE});
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        return bad;
    endfunction

    logic        w_req_bad;
    logic        w_not_dnload;
    logic        w_cmd_bad;
    logic [31:0] w_up_addr;
    logic [31:0] w_pend_addr;

    assign w_req_bad    = request_invalid(i_ctx.state, i_word);
    assign w_not_dnload = (i_word.request_code != dfurq_pkg::REQ_DNLOAD);
    // Block zero carries a DfuSe command: only the two known commands with a
    // five-byte payload are taken.
    assign w_cmd_bad    = (i_word.value == 16'd0) && (i_word.length != 16'd0) &&
                          (!(i_word.command_byte inside {dfurq_pkg::CMD_SET_ADDRESS,
                                                         dfurq_pkg::CMD_ERASE_PAGE}) ||
                           (i_word.length != dfurq_pkg::CMD_BLOCK_LEN));
    assign w_up_addr    = dfurq_pkg::block_address(i_ctx.addr_ptr, i_word.value);
    assign w_pend_addr  = dfurq_pkg::block_address(i_ctx.addr_ptr, i_ctx.blk_num);

    // Next context.
    always_comb begin
        o_ctx = i_ctx;
        case (i_word.kind)
            dfurq_pkg::KIND_VALIDATE: begin
                if (w_req_bad) begin
                    o_ctx.status = dfurq_pkg::SS_STALL;
                    o_ctx.state  = dfurq_pkg::ST_ERROR;
                end
            end
            dfurq_pkg::KIND_CHECK: begin
                if (!w_not_dnload && w_cmd_bad) begin
                    o_ctx.status = dfurq_pkg::SS_STALL;
                    o_ctx.state  = dfurq_pkg::ST_ERROR;
                end
            end
            dfurq_pkg::KIND_EXECUTE: begin
                case (i_word.request_code)
                    dfurq_pkg::REQ_DNLOAD: begin
                        o_ctx.blk_num = i_word.value;
                        o_ctx.blk_len = i_word.length;
                        o_ctx.cmd     = i_word.command_byte;
                        if (i_ctx.state inside {dfurq_pkg::ST_IDLE, dfurq_pkg::ST_DN_IDLE}) begin
                            o_ctx.state = (i_word.length != 16'd0) ? dfurq_pkg::ST_DN_SYNC
                                                                   : dfurq_pkg::ST_MAN_SYNC;
                        end
                    end
                    dfurq_pkg::REQ_UPLOAD: begin
                        o_ctx.state = (i_word.length < dfurq_pkg::MAX_XFER_LEN)
                                      ? dfurq_pkg::ST_IDLE : dfurq_pkg::ST_UP_IDLE;
                    end
                    dfurq_pkg::REQ_GETSTATUS: begin
                        if (i_ctx.state == dfurq_pkg::ST_DN_SYNC) begin
                            o_ctx.state = dfurq_pkg::ST_DN_BUSY;
                        end else if (i_ctx.state == dfurq_pkg::ST_MAN_SYNC) begin
                            o_ctx.state = dfurq_pkg::ST_MAN;
                        end
                    end
                    dfurq_pkg::REQ_CLRSTATUS: begin
                        o_ctx.status = dfurq_pkg::SS_OK;
                        o_ctx.state  = dfurq_pkg::ST_IDLE;
                    end
                    dfurq_pkg::REQ_ABORT: begin
                        o_ctx.state = dfurq_pkg::ST_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            dfurq_pkg::KIND_BLK_DONE: begin
                if (i_ctx.state == dfurq_pkg::ST_DN_BUSY) begin
                    if (i_ctx.blk_num == 16'd0) begin
                        // Only an address fault counts for a command block.
                        if (i_word.flash_outcome == dfurq_pkg::FLASH_BAD_ADDR) begin
                            o_ctx.status = dfurq_pkg::SS_TARGET;
                            o_ctx.state  = dfurq_pkg::ST_ERROR;
                        end else begin
                            if (i_ctx.cmd == dfurq_pkg::CMD_SET_ADDRESS) begin
                                o_ctx.addr_ptr = i_word.command_address;
                            end
                            o_ctx.state = dfurq_pkg::ST_DN_IDLE;
                        end
                    end else begin
                        case (i_word.flash_outcome)
                            dfurq_pkg::FLASH_BAD_ADDR: begin
                                o_ctx.status = dfurq_pkg::SS_TARGET;
                                o_ctx.state  = dfurq_pkg::ST_ERROR;
                            end
                            dfurq_pkg::FLASH_NOT_ERASED: begin
                                o_ctx.status = dfurq_pkg::SS_ERASED;
                                o_ctx.state  = dfurq_pkg::ST_ERROR;
                            end
                            dfurq_pkg::FLASH_VERIFY: begin
                                o_ctx.status = dfurq_pkg::SS_VERIFY;
                                o_ctx.state  = dfurq_pkg::ST_ERROR;
                            end
                            default: begin
                                o_ctx.state = dfurq_pkg::ST_DN_IDLE;
                            end
                        endcase
                    end
                end
            end
            dfurq_pkg::KIND_RESET: begin
                o_ctx.status   = dfurq_pkg::SS_OK;
                o_ctx.state    = dfurq_pkg::ST_IDLE;
                o_ctx.addr_ptr = i_addr_reset;
            end
            default: begin
            end
        endcase
    end

    // Reply word.
    always_comb begin
        logic        stall;
        logic [15:0] rlen;
        logic        clist;
        logic [23:0] poll;
        logic [31:0] taddr;
        stall = 1'b0;
        rlen  = 16'd0;
        clist = 1'b0;
        poll  = 24'd0;
        taddr = 32'd0;
        case (i_word.kind)
            dfurq_pkg::KIND_VALIDATE: begin
                stall = w_req_bad;
            end
            dfurq_pkg::KIND_CHECK: begin
                stall = w_not_dnload || w_cmd_bad;
            end
            dfurq_pkg::KIND_EXECUTE: begin
                case (i_word.request_code)
                    dfurq_pkg::REQ_DNLOAD, dfurq_pkg::REQ_CLRSTATUS,
                    dfurq_pkg::REQ_ABORT: begin
                    end
                    dfurq_pkg::REQ_UPLOAD: begin
                        if (i_word.value == 16'd0) begin
                            rlen  = (i_word.length < dfurq_pkg::CMD_LIST_LEN)
                                    ? i_word.length : dfurq_pkg::CMD_LIST_LEN;
                            clist = 1'b1;
                        end else begin
                            rlen  = i_word.length;
                            taddr = w_up_addr;
                        end
                    end
                    dfurq_pkg::REQ_GETSTATUS: begin
                        rlen = dfurq_pkg::STATUS_SIZE;
                        if (i_ctx.state inside {dfurq_pkg::ST_DN_SYNC, dfurq_pkg::ST_DN_BUSY}) begin
                            poll = i_word.busy_poll_time;
                        end
                    end
                    dfurq_pkg::REQ_GETSTATE: begin
                        rlen = 16'd1;
                    end
                    default: begin
                        stall = 1'b1;
                    end
                endcase
            end
            dfurq_pkg::KIND_BLK_DONE: begin
                if (i_ctx.state == dfurq_pkg::ST_DN_BUSY) begin
                    taddr = (i_ctx.blk_num == 16'd0) ? i_word.command_address : w_pend_addr;
                end
            end
            default: begin
            end
        endcase
        o_res.stall_res             = stall;
        o_res.dfu_state_out         = o_ctx.state;
        o_res.dfu_status_out        = o_ctx.status;
        o_res.reply_length          = stall ? 16'd0 : rlen;
        o_res.reply_is_command_list = stall ? 1'b0 : clist;
        o_res.poll_timeout          = poll;
        o_res.target_address        = taddr;
    end

endmodule

// ----- hw/rtl/dfu_request_state_machine_top.sv -----
// ----------------------------------------------------------------------------
// DFU request engine top level
// Order: a reply word enters the reply register as its request word leaves
// the input register, and it leaves the reply register when the sink takes it.
// Throughput: one request word per cycle; the input register, the step logic
// and the reply register form a two-stage pipeline with backpressure.
// Reset: synchronous, active low; state returns to dfuIDLE, status ok, and
// the address pointer and its restore value to 0x08000000.
// ----------------------------------------------------------------------------
module dfu_request_state_machine_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    dfurq_in_if.sink          i_in,
    dfurq_out_if.source       o_out
);

    logic                 r_in_vld;
    logic                 n_in_vld;
    dfurq_pkg::t_in_word  r_in;
    logic                 r_out_vld;
    logic                 n_out_vld;
    dfurq_pkg::t_out_word r_out;
    dfurq_pkg::t_out_word n_out;
    dfurq_pkg::t_ctx      r_ctx;
    dfurq_pkg::t_ctx      n_ctx;
    logic [31:0]          r_addr_reset;

    logic w_out_free;
    logic w_move;
    logic w_in_take;

    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_move     = r_in_vld && w_out_free;
    assign i_in.ready = !r_in_vld || w_move;
    assign w_in_take  = i_in.valid && i_in.ready;
    assign n_in_vld   = w_in_take || (r_in_vld && !w_move);
    assign n_out_vld  = w_move || (r_out_vld && !o_out.ready);

    dfurq_step u_step (
        .i_ctx        (r_ctx),
        .i_word       (r_in),
        .i_addr_reset (r_addr_reset),
        .o_ctx        (n_ctx),
        .o_res        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_addr_reset   <= dfurq_pkg::ADDR_RESET_DEFAULT;
            r_ctx.state    <= dfurq_pkg::ST_IDLE;
            r_ctx.status   <= dfurq_pkg::SS_OK;
            r_ctx.blk_num  <= 16'd0;
            r_ctx.blk_len  <= 16'd0;
            r_ctx.cmd      <= 8'd0;
            r_ctx.addr_ptr <= dfurq_pkg::ADDR_RESET_DEFAULT;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_addr_reset <= i_cfg_wdata;
            end
            // The context advances exactly once per word, as it leaves the
            // input register.
            if (w_move) begin
                r_ctx <= n_ctx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.kind            <= i_in.kind;
            r_in.request_type    <= i_in.request_type;
            r_in.request_code    <= i_in.request_code;
            r_in.value           <= i_in.value;
            r_in.index           <= i_in.index;
            r_in.length          <= i_in.length;
            r_in.command_byte    <= i_in.command_byte;
            r_in.command_address <= i_in.command_address;
            r_in.flash_outcome   <= i_in.flash_outcome;
            r_in.busy_poll_time  <= i_in.busy_poll_time;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid                 = r_out_vld;
    assign o_out.stall_res             = r_out.stall_res;
    assign o_out.dfu_state_out         = r_out.dfu_state_out;
    assign o_out.dfu_status_out        = r_out.dfu_status_out;
    assign o_out.reply_length          = r_out.reply_length;
    assign o_out.reply_is_command_list = r_out.reply_is_command_list;
    assign o_out.poll_timeout          = r_out.poll_timeout;
    assign o_out.target_address        = r_out.target_address;

endmodule

// ----- hw/rtl/dfurq_checker.sv -----
// ----------------------------------------------------------------------------
// DFU request engine checker
// Port-level properties of the DFU request engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "dfu_request_state_machine_top_assert.svh"

module dfurq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_stall_res,
    input logic [3:0]  i_state,
    input logic [15:0] i_reply_length,
    input logic        i_cmd_list,
    input logic [23:0] i_poll_timeout,
    input logic [31:0] i_target_address
);

    // No reply word may survive a reset.
    `DFURQ_ASSERT_RESET(a_rst_clears_out, !i_rst_n, !i_out_valid)

    // A rejected word never carries a data stage.
    `DFURQ_ASSERT_IMPL(a_stall_no_data, i_out_valid && i_stall_res,
        (i_reply_length == 16'd0) && !i_cmd_list)

    // A poll time is only reported once the download is busy.
    `DFURQ_ASSERT_IMPL(a_poll_only_busy, i_out_valid && (i_poll_timeout != 24'd0),
        i_state == dfurq_pkg::ST_DN_BUSY)

    // The command list reply is at most three bytes.
    `DFURQ_ASSERT_IMPL(a_cmd_list_len, i_out_valid && i_cmd_list,
        i_reply_length <= dfurq_pkg::CMD_LIST_LEN)

    // A waiting reply word is held until it is taken.
    `DFURQ_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_state) && $stable(i_target_address))

endmodule

bind dfu_request_state_machine_top dfurq_checker u_dfurq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_stall_res      (o_out.stall_res),
    .i_state          (o_out.dfu_state_out),
    .i_reply_length   (o_out.reply_length),
    .i_cmd_list       (o_out.reply_is_command_list),
    .i_poll_timeout   (o_out.poll_timeout),
    .i_target_address (o_out.target_address)
);
